### hdl/eeq_pkg.sv
// ----------------------------------------------------------------------------
// eeq_pkg
// Shared types and constants for the element equality search block.
// ----------------------------------------------------------------------------
package eeq_pkg;

  // Largest array length that is indexed; longer arrays raise too_long.
  localparam longint MAX_ELEMENTS = 65536;
  localparam int     CNT_W        = $clog2(MAX_ELEMENTS) + 1;
  localparam int     IDX_W        = 16;
  localparam int     LANES        = 8;
  localparam int     CNT_IN_W     = 4;
  localparam int     LANE_W       = 3;

  // Queue between front and back.
  localparam int     QDEPTH       = 4;
  localparam int     QPTR_W       = $clog2(QDEPTH);

  // Register indexes on the config port.
  localparam logic [1:0] REG_SIZE    = 2'd0;
  localparam logic [1:0] REG_REVERSE = 2'd1;
  localparam logic [1:0] REG_KEY     = 2'd2;

  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_HALF  = 2'd1,
    SZ_WORD  = 2'd2,
    SZ_DWORD = 2'd3
  } size_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [LANES-1:0]    hit_mask;  // lanes equal to key, already limited to count
    logic [CNT_IN_W-1:0] count;     // valid lanes after saturation
    logic                last;
    logic                reverse;
  } entry_t;

  typedef struct packed {
    logic             too_long;
    logic [IDX_W-1:0] match_index;
    logic             found;
  } result_t;

endpackage

### hdl/eeq_front.sv
// ----------------------------------------------------------------------------
// eeq_front
// Lane compare of one data word against the key, per element width.
// ----------------------------------------------------------------------------
module eeq_front (
  input  logic [63:0]                   data_word,
  input  logic [eeq_pkg::CNT_IN_W-1:0]  valid_count,
  input  logic                          last_word,
  input  eeq_pkg::size_t                element_size,
  input  logic                          search_reverse,
  input  logic [63:0]                   search_key,
  output eeq_pkg::entry_t               entry
);
  import eeq_pkg::*;

  logic [LANES-1:0]    be1, be2, be4, be8;
  logic [LANES-1:0]    eq;
  logic [CNT_IN_W-1:0] lanes;
  logic [CNT_IN_W-1:0] count_sat;

  // Byte compares against the key byte that sits at the same offset in an element.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      be1[i] = data_word[8*i +: 8] == search_key[7:0];
      be2[i] = data_word[8*i +: 8] == search_key[8*(i%2) +: 8];
      be4[i] = data_word[8*i +: 8] == search_key[8*(i%4) +: 8];
      be8[i] = data_word[8*i +: 8] == search_key[8*i +: 8];
    end
  end

  always_comb begin
    eq = '0;
    unique case (element_size)
      SZ_BYTE: begin
        eq    = be1;
        lanes = CNT_IN_W'(8);
      end
      SZ_HALF: begin
        for (int j = 0; j < 4; j++) eq[j] = &be2[2*j +: 2];
        lanes = CNT_IN_W'(4);
      end
      SZ_WORD: begin
        for (int j = 0; j < 2; j++) eq[j] = &be4[4*j +: 4];
        lanes = CNT_IN_W'(2);
      end
      default: begin
        eq[0] = &be8;
        lanes = CNT_IN_W'(1);
      end
    endcase
  end

  always_comb begin
    count_sat = (valid_count > lanes) ? lanes : valid_count;
    for (int i = 0; i < LANES; i++) begin
      entry.hit_mask[i] = eq[i] && (CNT_IN_W'(i) < count_sat);
    end
    entry.count   = count_sat;
    entry.last    = last_word;
    entry.reverse = search_reverse;
  end

endmodule

### hdl/eeq_queue.sv
// ----------------------------------------------------------------------------
// eeq_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module eeq_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  eeq_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output eeq_pkg::entry_t pop_data,
  output logic            not_empty
);
  import eeq_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full      = fill == (QPTR_W+1)'(QDEPTH);
  assign not_empty = fill != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= (QPTR_W+1)'(QDEPTH))
    else $error("queue fill above depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

### hdl/eeq_back.sv
// ----------------------------------------------------------------------------
// eeq_back
// Array state: element count, recorded match, overflow; result register.
// ----------------------------------------------------------------------------
module eeq_back (
  input  logic             clk,
  input  logic             rst,
  input  eeq_pkg::entry_t  entry,
  input  logic             entry_valid,
  output logic             entry_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output eeq_pkg::result_t res
);
  import eeq_pkg::*;

  logic [CNT_W-1:0]    counter;
  logic                hit_seen;
  logic [IDX_W-1:0]    hit_index;
  logic                overflow_seen;

  logic [CNT_W-1:0]    remaining;
  logic                over;
  logic [CNT_IN_W-1:0] avail;
  logic [LANES-1:0]    hits;
  logic                any_hit;
  logic [LANE_W-1:0]   first_lane;
  logic [LANE_W-1:0]   last_lane;
  logic [LANE_W-1:0]   pick;
  logic                take;

  logic [CNT_W-1:0]    counter_next;
  logic                hit_seen_next;
  logic [IDX_W-1:0]    hit_index_next;
  logic                overflow_seen_next;

  always_comb begin
    remaining = CNT_W'(MAX_ELEMENTS) - counter;
    over      = CNT_W'(entry.count) > remaining;
    avail     = over ? remaining[CNT_IN_W-1:0] : entry.count;
    for (int i = 0; i < LANES; i++) begin
      hits[i] = entry.hit_mask[i] && (CNT_IN_W'(i) < avail);
    end
    any_hit    = |hits;
    first_lane = '0;
    for (int i = LANES-1; i >= 0; i--) begin
      if (hits[i]) first_lane = LANE_W'(i);
    end
    last_lane = '0;
    for (int i = 0; i < LANES; i++) begin
      if (hits[i]) last_lane = LANE_W'(i);
    end
    pick = entry.reverse ? last_lane : first_lane;
    take = any_hit && (entry.reverse || !hit_seen);

    counter_next       = counter + CNT_W'(avail);
    hit_seen_next      = hit_seen || any_hit;
    hit_index_next     = take ? IDX_W'(counter + CNT_W'(pick)) : hit_index;
    overflow_seen_next = overflow_seen || over;
  end

  // Only the last word of an array needs room in the result register.
  assign entry_pop = entry_valid && (!entry.last || !res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      counter       <= '0;
      hit_seen      <= 1'b0;
      hit_index     <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (entry_pop) begin
        if (entry.last) begin
          res_valid     <= 1'b1;
          counter       <= '0;
          hit_seen      <= 1'b0;
          hit_index     <= '0;
          overflow_seen <= 1'b0;
        end else begin
          counter       <= counter_next;
          hit_seen      <= hit_seen_next;
          hit_index     <= hit_index_next;
          overflow_seen <= overflow_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_pop && entry.last) begin
      res.found       <= hit_seen_next;
      res.match_index <= hit_seen_next ? hit_index_next : '0;
      res.too_long    <= overflow_seen_next;
    end
  end

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    counter <= CNT_W'(MAX_ELEMENTS))
    else $error("element counter past limit");
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    hit_seen |-> CNT_W'(hit_index) < counter)
    else $error("recorded match beyond elements seen");
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> counter == CNT_W'(MAX_ELEMENTS))
    else $error("overflow flagged before counter saturated");
`endif

endmodule

### hdl/element_equality_search.sv
// ----------------------------------------------------------------------------
// element_equality_search
// Streaming find-first / find-last of an element equal to a key.
// ----------------------------------------------------------------------------
// Takes an array as a stream of 64-bit words of packed little-endian elements
// (1, 2, 4 or 8 bytes, set by element_size) and returns one result item per
// array, on the word flagged by tlast: found, the index of the first match
// (search_reverse = 0) or last match (search_reverse = 1), and too_long when
// more than 65536 elements arrived. One input item is accepted every clock
// while the queue has room; the front compares all lanes of a word
// combinationally and the back folds one word per cycle into the running
// count and match index, but holds a last word while a result is untaken.
// A result passes through the queue, then the result register. A four-entry
// item queue sits between front and back, and the result register lets the
// next array stream in while a result waits; input stalls only when the
// queue fills behind an untaken result. Registers (64-bit APB, 8-byte
// stride): 0x00 element_size, 0x08 search_reverse, 0x10 search_key; write
// them only while no array is in flight.
// ----------------------------------------------------------------------------
module element_equality_search (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [63:0] data_word, [67:64] valid_count, [71:68] zero
  input  logic        s_axis_tlast,  // last_word
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // [0] found, [16:1] match_index, [17] too_long, [23:18] zero
);
  import eeq_pkg::*;

  size_t       element_size;
  logic        search_reverse;
  logic [63:0] search_key;

  logic [1:0]  reg_sel;
  logic        cfg_wr;

  entry_t      front_entry;
  entry_t      back_entry;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  logic        push;
  result_t     res;

  // Config registers; register index from the 8-byte slot.
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_size   <= SZ_BYTE;
      search_reverse <= 1'b0;
      search_key     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SIZE:    element_size   <= size_t'(pwdata[1:0]);
        REG_REVERSE: search_reverse <= pwdata[0];
        REG_KEY:     search_key     <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SIZE:    prdata = {62'd0, element_size};
      REG_REVERSE: prdata = {63'd0, search_reverse};
      REG_KEY:     prdata = search_key;
      default:     prdata = '0;
    endcase
  end

  // Front: lane compares; items go straight into the queue.
  eeq_front u_front (
    .data_word      (s_axis_tdata[63:0]),
    .valid_count    (s_axis_tdata[67:64]),
    .last_word      (s_axis_tlast),
    .element_size   (element_size),
    .search_reverse (search_reverse),
    .search_key     (search_key),
    .entry          (front_entry)
  );

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  eeq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (back_entry),
    .not_empty (q_not_empty)
  );

  // Back: running count, match pick, result register.
  eeq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (back_entry),
    .entry_valid (q_not_empty),
    .entry_pop   (q_pop),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res         (res)
  );

  assign m_axis_tdata = {6'd0, res.too_long, res.match_index, res.found};

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the element equality search block.
// ----------------------------------------------------------------------------
// Streams arrays of packed words into the block and checks every result item
// against a cycle-free model of the search kept in this file. A short table
// of directed arrays runs first. It covers empty arrays, counts above the lane
// count, both search directions and every element size. It also has two
// arrays at the 64K element limit: one ends exactly there and one runs
// past it. Random phases follow, one register setting per phase, with bursts
// of source gaps and sink stalls. The last phases run without any idling.
// ----------------------------------------------------------------------------
module testbench;
  import eeq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_WORDS  = 75;
  localparam int unsigned SETTLE_TICKS = 8;

  // One row of the directed plan. The register values are written when the row
  // opens an array. reps repeats the same word. A row with has_want carries its
  // expected result typed in; every other row is checked against the model.
  typedef struct packed {
    logic [1:0]  size;
    logic        rev;
    logic [63:0] key;
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [15:0] reps;
    logic        has_want;
    result_t     want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;    // [63:0] data_word, [67:64] valid_count, [71:68] zero
  logic        s_axis_tlast = 1'b0;  // last_word
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [0] found, [16:1] match_index, [17] too_long

  // Travels with the word on the bus: a typed-in expected result, if any.
  logic        word_has_want = 1'b0;
  result_t     word_want = '0;

  // Register copies, updated when a write completes.
  size_t       cfg_size = SZ_BYTE;
  logic        cfg_reverse = 1'b0;
  logic [63:0] cfg_key = '0;

  // Search state of the array now streaming.
  logic [CNT_W-1:0] arr_count = '0;
  logic             arr_hit = 1'b0;
  logic [IDX_W-1:0] arr_hit_at = '0;
  logic             arr_over = 1'b0;

  result_t     due_results[$];   // expected results, oldest first
  plan_row_t   plan[$];
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap_pct = 0;   // chance that a word is preceded by a gap
  int unsigned snk_stall_pct = 0; // per-cycle chance that a sink stall begins

  element_equality_search dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("element_equality_search verification failed");
      $finish;
    end
  end

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Folds one word into the search state. Returns 1 on the last word, with the
  // result in res; the array state is then cleared for the next array.
  function automatic bit fold_word(input logic [63:0] data, input logic [3:0] count,
                                   input logic last, output result_t res);
    int unsigned width;
    int unsigned lanes;
    int unsigned used;
    logic [63:0] lane_mask;
    logic [63:0] elem;
    width = 8 << cfg_size;
    lanes = 8 >> cfg_size;
    used = (count > lanes) ? lanes : count;   // count saturates to the lane count
    lane_mask = (width == 64) ? {64{1'b1}} : ((64'd1 << width) - 64'd1);
    res = '0;
    for (int lane = 0; lane < used; lane++) begin
      elem = (data >> (lane * width)) & lane_mask;
      if (arr_count >= MAX_ELEMENTS) begin
        // past the limit: not compared, counter stays put
        arr_over = 1'b1;
      end else begin
        if (elem == (cfg_key & lane_mask) && (cfg_reverse || !arr_hit)) begin
          arr_hit = 1'b1;
          arr_hit_at = arr_count[IDX_W-1:0];
        end
        arr_count = arr_count + 1'b1;
      end
    end
    if (!last) return 1'b0;
    res.found = arr_hit;
    res.match_index = arr_hit ? arr_hit_at : '0;
    res.too_long = arr_over;
    arr_count = '0;
    arr_hit = 1'b0;
    arr_hit_at = '0;
    arr_over = 1'b0;
    return 1'b1;
  endfunction

  // Result checking, input tracking and the sink's stall bursts, all on one edge.
  // Outputs are checked before the word accepted on the same edge is folded in.
  always @(posedge clk) begin : watch
    result_t     got;
    result_t     want;
    result_t     predicted;
    int unsigned stall_left;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[17:0]);
        if (due_results.size() == 0) begin
          flag($sformatf("unexpected result: found=%0d index=%0d too_long=%0d",
                         got.found, got.match_index, got.too_long));
        end else begin
          want = due_results.pop_front();
          if (got.found !== want.found || got.match_index !== want.match_index ||
              got.too_long !== want.too_long)
            flag($sformatf({"result mismatch: expected found=%0d index=%0d too_long=%0d,",
                            " got found=%0d index=%0d too_long=%0d"},
                           want.found, want.match_index, want.too_long,
                           got.found, got.match_index, got.too_long));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (fold_word(s_axis_tdata[63:0], s_axis_tdata[67:64], s_axis_tlast, predicted))
          due_results.push_back(word_has_want ? word_want : predicted);
      end
    end
    // sink stalls come in bursts
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) < snk_stall_pct) begin
      stall_left = $urandom_range(13, 0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Presents one word, after an optional gap, and waits until it is taken.
  task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                           input logic last, input logic has_want, input result_t want);
    int unsigned gap;
    if ($urandom_range(99) < src_gap_pct) begin
      gap = $urandom_range(14, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, count, data};
    s_axis_tlast <= last;
    word_has_want <= has_want;
    word_want <= want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  // Waits for every expected result, then lets the pipeline run dry.
  task automatic settle();
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    logic [63:0] stored;
    logic [63:0] seen;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);            // write lands here
    penable <= 1'b0;           // psel stays high: read setup
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    seen = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SIZE: begin
        stored = {62'd0, value[1:0]};
        cfg_size = size_t'(value[1:0]);
      end
      REG_REVERSE: begin
        stored = {63'd0, value[0]};
        cfg_reverse = value[0];
      end
      default: begin
        stored = value;
        cfg_key = value;
      end
    endcase
    if (seen !== stored)
      flag($sformatf("register %0d read back: expected %h, got %h", idx, stored, seen));
  endtask

  // Stops the stream, drains, and writes whatever registers change.
  task automatic apply_config(input logic [1:0] size, input logic rev, input logic [63:0] key);
    s_axis_tvalid <= 1'b0;
    settle();
    if (size != cfg_size) write_reg(REG_SIZE, {62'd0, size});
    if (rev != cfg_reverse) write_reg(REG_REVERSE, {63'd0, rev});
    if (key != cfg_key) write_reg(REG_KEY, key);
  endtask

  task automatic add_row(input logic [1:0] size, input logic rev, input logic [63:0] key,
                         input logic [63:0] data, input logic [3:0] count, input logic last,
                         input int reps, input logic has_want, input logic found,
                         input logic [15:0] idx, input logic too_long);
    plan_row_t row;
    row.size = size;
    row.rev = rev;
    row.key = key;
    row.data = data;
    row.count = count;
    row.last = last;
    row.reps = reps[15:0];
    row.has_want = has_want;
    row.want.found = found;
    row.want.match_index = idx;
    row.want.too_long = too_long;
    plan.push_back(row);
  endtask

  // Random array under the current setting: mostly full words, some short or
  // over-long counts, and the key planted in about one lane of six.
  task automatic send_random_array();
    int unsigned n_words;
    int unsigned width;
    int unsigned lanes;
    int unsigned count;
    int unsigned pick;
    logic [63:0] data;
    logic [63:0] lane_mask;
    width = 8 << cfg_size;
    lanes = 8 >> cfg_size;
    lane_mask = (width == 64) ? {64{1'b1}} : ((64'd1 << width) - 64'd1);
    n_words = ($urandom_range(3) == 0) ? 1 : $urandom_range(12, 1);
    for (int w = 0; w < n_words; w++) begin
      data = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick == 0) count = $urandom_range(15);
      else if (pick == 1) count = $urandom_range(lanes);
      else count = lanes;
      for (int lane = 0; lane < lanes; lane++)
        if ($urandom_range(5) == 0)
          data = (data & ~(lane_mask << (lane * width))) |
                 ((cfg_key & lane_mask) << (lane * width));
      send_word(data, count[3:0], w == n_words - 1, 1'b0, '0);
    end
  endtask

  initial begin : run
    logic        array_open;
    logic [63:0] key;
    int unsigned phase_end;

    // empty array straight after reset
    add_row(SZ_BYTE, 0, '0, '0, 0, 1, 1, 1, 0, 0, 0);
    // all-ones data against a zero key
    add_row(SZ_BYTE, 0, '0, '1, 8, 1, 1, 1, 0, 0, 0);
    // two byte hits, first then last; only the low byte of the key counts
    add_row(SZ_BYTE, 0, '1, 64'h00FF_00FF_0000_0000, 8, 0, 1, 0, 0, 0, 0);
    add_row(SZ_BYTE, 0, '1, '0, 8, 1, 1, 1, 1, 4, 0);
    add_row(SZ_BYTE, 1, '1, 64'h00FF_00FF_0000_0000, 8, 0, 1, 0, 0, 0, 0);
    add_row(SZ_BYTE, 1, '1, '0, 8, 1, 1, 1, 1, 6, 0);
    // counts above the lane count saturate
    add_row(SZ_DWORD, 0, '1, '1, 15, 1, 1, 1, 1, 0, 0);
    add_row(SZ_WORD, 0, 64'hDEAD_BEEF_1234_5678, 64'h1234_5678_0000_0000, 9, 1, 1,
            1, 1, 1, 0);
    // key sits in a lane beyond the count
    add_row(SZ_HALF, 0, 64'hBEEF, 64'hBEEF_0000_0000_0000, 3, 1, 1, 1, 0, 0, 0);
    // reverse across words, with an empty word in the middle
    add_row(SZ_HALF, 1, 64'hBEEF, 64'hBEEF_0000_BEEF_0001, 4, 0, 1, 0, 0, 0, 0);
    add_row(SZ_HALF, 1, 64'hBEEF, 64'h0000_0000_0000_BEEF, 0, 0, 1, 0, 0, 0, 0);
    add_row(SZ_HALF, 1, 64'hBEEF, 64'h0000_0000_0000_BEEF, 1, 1, 1, 0, 0, 0, 0);
    // empty multi-word array: data equals the key but nothing is counted
    add_row(SZ_DWORD, 0, '0, '0, 0, 0, 1, 0, 0, 0, 0);
    add_row(SZ_DWORD, 0, '0, '0, 0, 1, 1, 1, 0, 0, 0);
    // forward over repeated 32-bit hits
    add_row(SZ_WORD, 0, 64'h8000_0001, 64'h8000_0001_0000_0000, 2, 0, 1, 0, 0, 0, 0);
    add_row(SZ_WORD, 0, 64'h8000_0001, 64'h8000_0001_8000_0001, 2, 1, 1, 0, 0, 0, 0);
    // too long: hits past the limit are dropped, the early one stays
    add_row(SZ_BYTE, 1, 64'h5A, 64'h0000_0000_005A_0000, 8, 0, 1, 0, 0, 0, 0);
    add_row(SZ_BYTE, 1, 64'h5A, '0, 8, 0, 8191, 0, 0, 0, 0);
    add_row(SZ_BYTE, 1, 64'h5A, 64'h5A5A_5A5A_5A5A_5A5A, 8, 1, 1, 1, 1, 2, 1);
    // exactly at the limit: last element is a hit at the top index
    add_row(SZ_BYTE, 0, 64'h5A, 64'h1111_1111_1111_1111, 8, 0, 8191, 0, 0, 0, 0);
    add_row(SZ_BYTE, 0, 64'h5A, 64'h5A11_1111_1111_1111, 8, 1, 1, 1, 1, 16'hFFFF, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    src_gap_pct = 20;
    snk_stall_pct = 10;
    array_open = 1'b0;
    foreach (plan[i]) begin
      if (!array_open && (plan[i].size != cfg_size || plan[i].rev != cfg_reverse ||
                          plan[i].key != cfg_key))
        apply_config(plan[i].size, plan[i].rev, plan[i].key);
      repeat (plan[i].reps)
        send_word(plan[i].data, plan[i].count, plan[i].last, plan[i].has_want,
                  plan[i].want);
      array_open = !plan[i].last;
    end

    // Random phases walk all size/direction pairs; the final two are idle-free.
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(3))
        0: key = '0;
        1: key = '1;
        default: key = {$urandom, $urandom};
      endcase
      apply_config(2'(phase % 4), 1'((phase / 4) % 2), key);
      if (phase >= PHASES - 2) begin
        src_gap_pct = 0;
        snk_stall_pct = 0;
      end else begin
        src_gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
        snk_stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(15, 2);
      end
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) send_random_array();
    end

    s_axis_tvalid <= 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("element_equality_search verification clean");
    end else begin
      $display("element_equality_search verification failed");
    end
    $finish;
  end

endmodule

### element_equality_search.f
hdl/eeq_pkg.sv
hdl/eeq_front.sv
hdl/eeq_queue.sv
hdl/eeq_back.sv
hdl/element_equality_search.sv
dv/testbench.sv
